FILE: hdl/bll_pkg.sv
`default_nettype none

package bll_pkg;

    // Frame store and hit count depth
    localparam int MAX_SAMPLES = 65536;
    localparam int IDX_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int LEN_W       = IDX_W + 1;

    // Field and register widths
    localparam int SAMPLE_W    = 8;
    localparam int POS_W       = 16;
    localparam int CNT_W       = 5;
    localparam int THR_W       = 8;
    localparam int LIM_W       = 5;
    localparam int FLEN_W      = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;

    // Result queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CNT_W-1:0]  COUNT_MAX          = '1;
    localparam logic [THR_W-1:0]  THRESHOLD_RESET    = 8'd235;
    localparam logic [LIM_W-1:0]  HIT_LIMIT_RESET    = 5'd10;
    localparam logic [FLEN_W-1:0] FRAME_LENGTH_RESET = FLEN_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD    = 2'd0,
        CFG_HIT_LIMIT    = 2'd1,
        CFG_FRAME_LENGTH = 2'd2
    } cfg_index_t;

    // One finished pair: largest gap and where it first occurred
    typedef struct packed {
        logic [SAMPLE_W-1:0] max_gap;
        logic [IDX_W-1:0]    position;
    } bll_result_t;

    typedef struct packed {
        logic        valid;
        bll_result_t data;
    } bll_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } bll_qstat_t;

    // Frame length clamped to 1 .. MAX_SAMPLES
    function automatic logic [LEN_W-1:0] eff_length(input logic [FLEN_W-1:0] fl);
        if (fl == '0) begin
            return LEN_W'(1);
        end else if (32'(fl) > 32'(MAX_SAMPLES)) begin
            return LEN_W'(MAX_SAMPLES);
        end else begin
            return LEN_W'(fl);
        end
    endfunction

    // Sample index as reported on the 16-bit position ports
    function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] p);
        logic [31:0] wide;
        wide = 32'(p);
        return wide[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bll_front.sv
`default_nettype none

module bll_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           busy,
    input  wire logic [bll_pkg::FLEN_W-1:0]     frame_length,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [bll_pkg::SAMPLE_W-1:0]   s_sample,
    input  wire bll_pkg::bll_qstat_t            qstat,
    output bll_pkg::bll_push_t                  push
);

    logic [bll_pkg::SAMPLE_W-1:0] frame_store [bll_pkg::MAX_SAMPLES];
    logic [bll_pkg::SAMPLE_W-1:0] stored_reg;

    logic                          second_reg;
    logic [bll_pkg::IDX_W-1:0]     idx_reg;
    logic [bll_pkg::LEN_W-1:0]     eff_len;
    logic [bll_pkg::LEN_W-1:0]     idx_plus;
    logic                          last0;
    logic                          accept;

    logic                          f1_valid_reg;
    logic                          f1_second_reg;
    logic                          f1_last_reg;
    logic [bll_pkg::SAMPLE_W-1:0]  f1_sample_reg;
    logic [bll_pkg::IDX_W-1:0]     f1_idx_reg;
    logic                          f1_free;
    logic                          f1_use;

    logic                          run_seen_reg;
    logic [bll_pkg::SAMPLE_W-1:0]  run_max_reg;
    logic [bll_pkg::IDX_W-1:0]     run_pos_reg;
    logic [bll_pkg::SAMPLE_W-1:0]  gap;
    logic                          better;
    logic [bll_pkg::SAMPLE_W-1:0]  max_next;
    logic [bll_pkg::IDX_W-1:0]     pos_next;

    // Index bookkeeping for the incoming item
    assign eff_len  = bll_pkg::eff_length(frame_length);
    assign idx_plus = {1'b0, idx_reg} + bll_pkg::LEN_W'(1);
    assign last0    = (idx_plus >= eff_len);

    // Stage 1 holds only when the end of a pair meets a full queue
    assign f1_free = !f1_valid_reg || !(f1_second_reg && f1_last_reg) || !qstat.full;
    assign s_ready = !busy && f1_free;
    assign accept  = s_valid && s_ready;
    assign f1_use  = f1_valid_reg && f1_second_reg && f1_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            second_reg <= 1'b0;
            idx_reg    <= '0;
        end else if (accept) begin
            if (last0) begin
                second_reg <= !second_reg;
                idx_reg    <= '0;
            end else begin
                idx_reg    <= idx_plus[bll_pkg::IDX_W-1:0];
            end
        end
    end

    // Frame store: written by the first frame, read by the second
    always_ff @(posedge aclk) begin
        if (accept && !second_reg) begin
            frame_store[idx_reg] <= s_sample;
        end
        if (accept && second_reg) begin
            stored_reg <= frame_store[idx_reg];
        end
    end

    // Stage 1 registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
        end else if (f1_free) begin
            f1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            f1_second_reg <= second_reg;
            f1_last_reg   <= last0;
            f1_sample_reg <= s_sample;
            f1_idx_reg    <= idx_reg;
        end
    end

    // Absolute difference and running maximum
    always_comb begin
        gap      = (f1_sample_reg >= stored_reg) ? (f1_sample_reg - stored_reg)
                                                 : (stored_reg - f1_sample_reg);
        better   = !run_seen_reg || (gap > run_max_reg);
        max_next = better ? gap : run_max_reg;
        pos_next = better ? f1_idx_reg : run_pos_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_seen_reg <= 1'b0;
            run_max_reg  <= '0;
            run_pos_reg  <= '0;
        end else if (f1_use) begin
            if (f1_last_reg) begin
                run_seen_reg <= 1'b0;
                run_max_reg  <= '0;
                run_pos_reg  <= '0;
            end else begin
                run_seen_reg <= 1'b1;
                run_max_reg  <= max_next;
                run_pos_reg  <= pos_next;
            end
        end
    end

    // End of a pair goes to the result queue
    assign push.valid         = f1_use && f1_last_reg;
    assign push.data.max_gap  = max_next;
    assign push.data.position = pos_next;

endmodule

`default_nettype wire

FILE: hdl/bll_queue.sv
`default_nettype none

module bll_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire bll_pkg::bll_push_t   push,
    input  wire logic                 pop,
    output bll_pkg::bll_qstat_t       qstat,
    output bll_pkg::bll_result_t      head
);

    bll_pkg::bll_result_t          entries [bll_pkg::QUEUE_DEPTH];
    logic [bll_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [bll_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [bll_pkg::QPTR_W:0]      count_reg;
    logic [bll_pkg::QPTR_W:0]      count_next;

    assign qstat.full  = (count_reg == (bll_pkg::QPTR_W + 1)'(bll_pkg::QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head        = entries[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push.valid && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push.valid && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push.valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            entries[wr_ptr_reg] <= push.data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.full |-> !push.valid)
        else $error("item pushed into full result queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.empty |-> !pop)
        else $error("item popped from empty result queue");
`endif

endmodule

`default_nettype wire

FILE: hdl/bll_back.sv
`default_nettype none

module bll_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [bll_pkg::THR_W-1:0]     threshold,
    input  wire logic [bll_pkg::LIM_W-1:0]     hit_limit,
    input  wire bll_pkg::bll_qstat_t           qstat,
    input  wire bll_pkg::bll_result_t          head,
    output logic                               pop,
    output logic                               busy,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [bll_pkg::SAMPLE_W-1:0]       m_max_gap,
    output logic [bll_pkg::POS_W-1:0]          m_gap_position,
    output logic                               m_hit,
    output logic                               m_detected,
    output logic [bll_pkg::POS_W-1:0]          m_light_position
);

    logic [bll_pkg::CNT_W-1:0]  hit_counts [bll_pkg::MAX_SAMPLES];
    logic [bll_pkg::CNT_W-1:0]  cnt_rd_reg;

    logic                       clear_active_reg;
    logic [bll_pkg::IDX_W-1:0]  clear_idx_reg;

    logic                       b2_valid_reg;
    bll_pkg::bll_result_t       b2_entry_reg;
    logic                       fwd_hit_reg;
    logic [bll_pkg::CNT_W-1:0]  fwd_val_reg;

    logic                       m_valid_reg;
    logic                       found_reg;
    logic [bll_pkg::IDX_W-1:0]  found_pos_reg;
    logic                       found_next;
    logic [bll_pkg::IDX_W-1:0]  found_pos_next;

    logic                       out_free;
    logic                       b2_fire;
    logic [bll_pkg::CNT_W-1:0]  old_cnt;
    logic [bll_pkg::CNT_W-1:0]  new_cnt;
    logic                       hit;
    logic                       cnt_we;
    logic                       detect;

    assign busy    = clear_active_reg;
    assign m_valid = m_valid_reg;

    // Handshake between queue, count lookup stage and output register
    assign out_free = !m_valid_reg || m_ready;
    assign b2_fire  = b2_valid_reg && out_free;
    assign pop      = !qstat.empty && !clear_active_reg && (!b2_valid_reg || b2_fire);

    // Count update; forwarded value covers a write in the lookup cycle
    always_comb begin
        old_cnt        = fwd_hit_reg ? fwd_val_reg : cnt_rd_reg;
        hit            = b2_entry_reg.max_gap > threshold;
        new_cnt        = (old_cnt == bll_pkg::COUNT_MAX) ? old_cnt : old_cnt + 1'b1;
        cnt_we         = b2_fire && hit;
        detect         = cnt_we && (old_cnt > hit_limit) && !found_reg;
        found_next     = found_reg || detect;
        found_pos_next = detect ? b2_entry_reg.position : found_pos_reg;
    end

    // Clearing pass over the hit counts after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_active_reg <= 1'b1;
            clear_idx_reg    <= '0;
        end else if (clear_active_reg) begin
            clear_idx_reg <= clear_idx_reg + 1'b1;
            if (clear_idx_reg == bll_pkg::IDX_W'(bll_pkg::MAX_SAMPLES - 1)) begin
                clear_active_reg <= 1'b0;
            end
        end
    end

    // Hit count memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (clear_active_reg) begin
            hit_counts[clear_idx_reg] <= '0;
        end else if (cnt_we) begin
            hit_counts[b2_entry_reg.position] <= new_cnt;
        end
        if (pop) begin
            cnt_rd_reg <= hit_counts[head.position];
        end
    end

    // Lookup stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b2_valid_reg <= 1'b0;
        end else if (pop) begin
            b2_valid_reg <= 1'b1;
        end else if (b2_fire) begin
            b2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            b2_entry_reg <= head;
            fwd_hit_reg  <= cnt_we && (b2_entry_reg.position == head.position);
            fwd_val_reg  <= new_cnt;
        end
    end

    // Sticky detection
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg     <= 1'b0;
            found_pos_reg <= '0;
        end else begin
            found_reg     <= found_next;
            found_pos_reg <= found_pos_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b2_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b2_fire) begin
            m_max_gap        <= b2_entry_reg.max_gap;
            m_gap_position   <= bll_pkg::to_pos(b2_entry_reg.position);
            m_hit            <= hit;
            m_detected       <= found_next;
            m_light_position <= found_next ? bll_pkg::to_pos(found_pos_next) : '0;
        end
    end

`ifndef NO_ASSERTIONS
    a_found_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |=> found_reg && $stable(found_pos_reg))
        else $error("detected light position changed after detection");
    a_no_pop_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_active_reg |-> !pop && !b2_valid_reg)
        else $error("result processed during hit count clearing");
`endif

endmodule

`default_nettype wire

FILE: hdl/blinking_light_locator.sv
`default_nettype none

// Blinking light locator. Samples of camera frames arrive one per cycle while s_ready is
// high, frames taken in pairs of frame_length samples each; the first frame of a pair
// fills an on-chip frame store, the second is compared against it and at its last sample
// one result item gives the largest absolute difference, its first position, whether it
// beat the threshold and the sticky detected light position. The input side takes one
// sample every cycle unless a pair's end meets a full queue; its rate is set by the
// single-port frame store, one write or one read per sample. Results leave through a
// four-entry queue and a hit count stage that handles one result per cycle while m_ready
// is held high, with a forwarding path for back-to-back results at the same position, so
// at most one result per two samples never backs up the input. A result is formed after
// stage 1 and registered in the queue, the lookup stage and the output register. After
// reset a clearing pass zeroes all MAX_SAMPLES (65536) hit counts, during which s_ready
// is low; configuration writes are taken at all times and should only be made when idle.
module blinking_light_locator (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [bll_pkg::SAMPLE_W-1:0]     s_sample,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [bll_pkg::SAMPLE_W-1:0]          m_max_gap,
    output logic [bll_pkg::POS_W-1:0]             m_gap_position,
    output logic                                  m_hit,
    output logic                                  m_detected,
    output logic [bll_pkg::POS_W-1:0]             m_light_position,
    input  wire logic                             cfg_wr_en,
    input  wire logic [bll_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bll_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

    logic [bll_pkg::THR_W-1:0]   threshold_reg;
    logic [bll_pkg::LIM_W-1:0]   hit_limit_reg;
    logic [bll_pkg::FLEN_W-1:0]  frame_length_reg;

    logic                        busy;
    logic                        pop;
    bll_pkg::bll_push_t          push;
    bll_pkg::bll_qstat_t         qstat;
    bll_pkg::bll_result_t        head;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= bll_pkg::THRESHOLD_RESET;
            hit_limit_reg    <= bll_pkg::HIT_LIMIT_RESET;
            frame_length_reg <= bll_pkg::FRAME_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bll_pkg::CFG_THRESHOLD: begin
                    threshold_reg <= cfg_wr_data[bll_pkg::THR_W-1:0];
                end
                bll_pkg::CFG_HIT_LIMIT: begin
                    hit_limit_reg <= cfg_wr_data[bll_pkg::LIM_W-1:0];
                end
                bll_pkg::CFG_FRAME_LENGTH: begin
                    frame_length_reg <= cfg_wr_data[bll_pkg::FLEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    bll_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .busy         (busy),
        .frame_length (frame_length_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .qstat        (qstat),
        .push         (push)
    );

    bll_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .qstat   (qstat),
        .head    (head)
    );

    bll_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .threshold        (threshold_reg),
        .hit_limit        (hit_limit_reg),
        .qstat            (qstat),
        .head             (head),
        .pop              (pop),
        .busy             (busy),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_max_gap        (m_max_gap),
        .m_gap_position   (m_gap_position),
        .m_hit            (m_hit),
        .m_detected       (m_detected),
        .m_light_position (m_light_position)
    );

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bll_pkg::*;

    localparam int STALL_LIMIT    = 200000; // quiet-cycle watchdog; covers the clearing pass after reset
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_PHASES  = 8;
    localparam int PRESSURE_PHASE = 4;
    localparam int LONG_FRAME     = 80;

    typedef enum int {PAIR_BLINK, PAIR_SAME, PAIR_RANDOM} pair_style_t;
    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_ALTERNATE} rx_pattern_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] max_gap;
        logic [POS_W-1:0]    gap_position;
        logic                hit;
        logic                detected;
        logic [POS_W-1:0]    light_position;
    } pair_result_t;

    // DUT ports
    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [SAMPLE_W-1:0]   s_sample    = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [SAMPLE_W-1:0]   m_max_gap;
    logic [POS_W-1:0]      m_gap_position;
    logic                  m_hit;
    logic                  m_detected;
    logic [POS_W-1:0]      m_light_position;
    logic                  cfg_wr_en   = 1'b0;
    cfg_index_t            cfg_index   = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    // Locator state as seen by the predictor
    logic [SAMPLE_W-1:0] frame_mem [MAX_SAMPLES];
    logic [CNT_W-1:0]    hit_cnt   [MAX_SAMPLES];
    logic [THR_W-1:0]    cfg_thr = THRESHOLD_RESET;
    logic [LIM_W-1:0]    cfg_lim = HIT_LIMIT_RESET;
    logic [FLEN_W-1:0]   cfg_len = FRAME_LENGTH_RESET;
    bit                  in_second = 1'b0;
    int                  cur_index = 0;
    int                  run_max   = -1;
    int                  run_pos   = 0;
    bit                  found     = 1'b0;
    int                  found_pos = 0;

    pair_result_t        pending_pairs [$];
    logic [SAMPLE_W-1:0] samples_to_send [$];
    pair_result_t        want;
    int                  queued_cnt  = 0;
    int                  taken_cnt   = 0;
    int                  fail_cnt    = 0;
    int                  quiet_cycles = 0;
    logic                s_took      = 1'b0;

    // Sender and receiver pacing
    int          gap_left   = 0;
    int          burst_left = 0;
    int          gap_max    = 2;
    int          burst_max  = 4;
    bit          hold_req   = 1'b0;
    int          hold_left  = 0;
    rx_pattern_t rx_mode    = RX_ALWAYS;
    int          mode_left  = 0;
    int          rx_tick    = 0;

    blinking_light_locator dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_max_gap        (m_max_gap),
        .m_gap_position   (m_gap_position),
        .m_hit            (m_hit),
        .m_detected       (m_detected),
        .m_light_position (m_light_position),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    initial begin
        for (int i = 0; i < MAX_SAMPLES; i++) begin
            frame_mem[i] = '0;
            hit_cnt[i]   = '0;
        end
    end

    // Effective samples per frame, clamped to 1 .. MAX_SAMPLES
    function automatic int frame_span();
        if (cfg_len == '0) return 1;
        if (int'(cfg_len) > MAX_SAMPLES) return MAX_SAMPLES;
        return int'(cfg_len);
    endfunction

    // Advance the locator by one sample; queue the pair result when a pair closes
    function automatic void track_sample(input logic [SAMPLE_W-1:0] smp);
        pair_result_t res;
        int  span;
        int  at;
        int  diff;
        bit  last;
        span = frame_span();
        at   = (cur_index >= MAX_SAMPLES) ? MAX_SAMPLES - 1 : cur_index;
        last = (at + 1 >= span);

        // first frame of the pair: fill the store
        if (!in_second) begin
            frame_mem[at] = smp;
            if (last) begin
                in_second = 1'b1;
                cur_index = 0;
                run_max   = -1;
                run_pos   = 0;
            end else begin
                cur_index = at + 1;
            end
            return;
        end

        // second frame: track the largest gap, keep the first position on ties
        diff = int'(smp) - int'(frame_mem[at]);
        if (diff < 0) diff = -diff;
        if (diff > run_max) begin
            run_max = diff;
            run_pos = at;
        end
        if (!last) begin
            cur_index = at + 1;
            return;
        end

        res.max_gap      = SAMPLE_W'(run_max);
        res.gap_position = POS_W'(run_pos);
        res.hit          = (res.max_gap > cfg_thr);
        if (res.hit) begin
            // detection looks at the count before this hit
            if (hit_cnt[run_pos] > cfg_lim && !found) begin
                found     = 1'b1;
                found_pos = run_pos;
            end
            if (hit_cnt[run_pos] != COUNT_MAX)
                hit_cnt[run_pos] = hit_cnt[run_pos] + 1'b1;
        end
        res.detected       = found;
        res.light_position = found ? POS_W'(found_pos) : '0;
        pending_pairs.push_back(res);

        in_second = 1'b0;
        cur_index = 0;
        run_max   = -1;
        run_pos   = 0;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            fail_cnt++;
        end
    endtask

    // Monitor: predict on accepted samples, compare accepted results, watchdog
    always @(posedge aclk) begin
        s_took <= s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                track_sample(s_sample);
                taken_cnt++;
            end
            if (m_valid && m_ready) begin
                if (pending_pairs.size() == 0) begin
                    $error("result item with no pair pending: max_gap %0d position %0d",
                           m_max_gap, m_gap_position);
                    fail_cnt++;
                end else begin
                    want = pending_pairs.pop_front();
                    check_field("max_gap", 32'(want.max_gap), 32'(m_max_gap));
                    check_field("gap_position", 32'(want.gap_position),
                                32'(m_gap_position));
                    check_field("hit", 32'(want.hit), 32'(m_hit));
                    check_field("detected", 32'(want.detected), 32'(m_detected));
                    check_field("light_position", 32'(want.light_position),
                                32'(m_light_position));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    // Sample driver: bursts with random gaps, holds the item until taken
    always @(negedge aclk) begin
        if (!s_valid || s_took) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (samples_to_send.size() != 0) begin
                s_valid  <= 1'b1;
                s_sample <= samples_to_send.pop_front();
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, burst_max);
                    gap_left   = $urandom_range(0, gap_max);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: its own stall pattern, plus a long hold on request
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (mode_left == 0) begin
            rx_mode   = rx_pattern_t'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        rx_tick++;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:    m_ready <= 1'b1;
                RX_COIN:      m_ready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE:    m_ready <= ($urandom_range(0, 3) == 0);
                default:      m_ready <= rx_tick[0];
            endcase
        end
    end

    task automatic offer(input logic [SAMPLE_W-1:0] v);
        samples_to_send.push_back(v);
        queued_cnt++;
    endtask

    // Wait until every sample is taken and every pair result has come out
    task automatic wait_idle();
        while (taken_cnt != queued_cnt || pending_pairs.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_cfg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            CFG_THRESHOLD:    cfg_thr = THR_W'(data);
            CFG_HIT_LIMIT:    cfg_lim = LIM_W'(data);
            CFG_FRAME_LENGTH: cfg_len = data;
            default: ;
        endcase
    endtask

    // One full pair of frames; blink pairs put a clear peak over low noise
    task automatic send_pair(input int len, input pair_style_t style, input int blink_at);
        logic [SAMPLE_W-1:0] one [$];
        logic [SAMPLE_W-1:0] two [$];
        int p;
        int q;
        int g;
        int noise;
        int r;
        int x;
        bit tie;
        noise = $urandom_range(0, 40);
        g     = $urandom_range(noise + 1, 255);
        p     = (blink_at >= 0) ? blink_at : $urandom_range(0, len - 1);
        q     = $urandom_range(0, len - 1);
        tie   = (blink_at < 0) && ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
            x = $urandom_range(0, 255);
            case (style)
                PAIR_SAME: begin
                    one.push_back(SAMPLE_W'(x));
                    two.push_back(SAMPLE_W'(x));
                end
                PAIR_RANDOM: begin
                    one.push_back(SAMPLE_W'(x));
                    two.push_back(SAMPLE_W'($urandom_range(0, 255)));
                end
                default: begin
                    if (i == p || (tie && i == q)) begin
                        x = $urandom_range(0, 255 - g);
                        if ($urandom_range(0, 1)) begin
                            one.push_back(SAMPLE_W'(x));
                            two.push_back(SAMPLE_W'(x + g));
                        end else begin
                            one.push_back(SAMPLE_W'(x + g));
                            two.push_back(SAMPLE_W'(x));
                        end
                    end else begin
                        r = $urandom_range(0, noise);
                        one.push_back(SAMPLE_W'(x));
                        if ($urandom_range(0, 1))
                            two.push_back(SAMPLE_W'((x + r > 255) ? 255 : x + r));
                        else
                            two.push_back(SAMPLE_W'((x < r) ? 0 : x - r));
                    end
                end
            endcase
        end
        foreach (one[i]) offer(one[i]);
        foreach (two[i]) offer(two[i]);
    endtask

    initial begin : stimulus
        int ph;
        int span;
        int left;
        int start_cnt;
        int goal;
        int pick;
        pair_style_t style;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Single-sample frames, lowest threshold, hit limit that never detects
        write_cfg(CFG_THRESHOLD, '0);
        write_cfg(CFG_HIT_LIMIT, 17'd31);
        write_cfg(CFG_FRAME_LENGTH, '0);
        offer(8'd0);   offer(8'd255);
        offer(8'd255); offer(8'd0);
        offer(8'd0);   offer(8'd0);
        offer(8'd128); offer(8'd127);
        offer(8'd7);   offer(8'd7);
        wait_idle();

        // Tied maximum, highest threshold
        write_cfg(CFG_THRESHOLD, 17'd255);
        write_cfg(CFG_FRAME_LENGTH, 17'd3);
        offer(8'd10); offer(8'd20); offer(8'd30);
        offer(8'd10); offer(8'd25); offer(8'd25);
        wait_idle();

        // Oversized length, then shortened in the middle of the first frame
        write_cfg(CFG_FRAME_LENGTH, 17'h1FFFF);
        for (int i = 1; i <= 5; i++) offer(SAMPLE_W'(i));
        wait_idle();
        write_cfg(CFG_FRAME_LENGTH, 17'd2);
        offer(8'd6);
        offer(8'd1); offer(8'd200);
        wait_idle();

        // One pair at the longest length used below, peak on the last index; every
        // store entry that later frames can reach has been written after this
        write_cfg(CFG_THRESHOLD, 17'(THRESHOLD_RESET));
        write_cfg(CFG_HIT_LIMIT, 17'(HIT_LIMIT_RESET));
        write_cfg(CFG_FRAME_LENGTH, CFG_DATA_W'(LONG_FRAME));
        gap_max   = 1;
        burst_max = 64;
        send_pair(LONG_FRAME, PAIR_BLINK, LONG_FRAME - 1);
        wait_idle();

        // Random phases: settings redrawn at random, mostly blink pairs
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0 || $urandom_range(0, 1)) begin
                case ($urandom_range(0, 3))
                    0:       write_cfg(CFG_THRESHOLD, '0);
                    1:       write_cfg(CFG_THRESHOLD, 17'd255);
                    2:       write_cfg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 255)));
                    default: write_cfg(CFG_THRESHOLD,
                                       CFG_DATA_W'($urandom_range(150, 250)));
                endcase
            end
            if (ph == 0 || $urandom_range(0, 1)) begin
                case ($urandom_range(0, 3))
                    0:       write_cfg(CFG_HIT_LIMIT, '0);
                    1:       write_cfg(CFG_HIT_LIMIT, 17'd30);
                    2:       write_cfg(CFG_HIT_LIMIT, 17'd31);
                    default: write_cfg(CFG_HIT_LIMIT, CFG_DATA_W'($urandom_range(0, 31)));
                endcase
            end
            if (ph == 0 || $urandom_range(0, 1)) begin
                case ($urandom_range(0, 9))
                    0:          write_cfg(CFG_FRAME_LENGTH, '0);
                    1:          write_cfg(CFG_FRAME_LENGTH, 17'd1);
                    2:          write_cfg(CFG_FRAME_LENGTH, 17'd2);
                    3, 4, 5, 6: write_cfg(CFG_FRAME_LENGTH,
                                          CFG_DATA_W'($urandom_range(3, 12)));
                    7, 8:       write_cfg(CFG_FRAME_LENGTH,
                                          CFG_DATA_W'($urandom_range(13, 40)));
                    default:    write_cfg(CFG_FRAME_LENGTH,
                                          CFG_DATA_W'($urandom_range(41, LONG_FRAME)));
                endcase
            end
            // early phase tuned so a light gets detected
            if (ph == 1) begin
                write_cfg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 100)));
                write_cfg(CFG_HIT_LIMIT, CFG_DATA_W'($urandom_range(0, 3)));
                write_cfg(CFG_FRAME_LENGTH, CFG_DATA_W'($urandom_range(2, 6)));
            end

            case ($urandom_range(0, 2))
                0: begin gap_max = 0;  burst_max = 64; end
                1: begin gap_max = 3;  burst_max = 8;  end
                default: begin gap_max = 12; burst_max = 3; end
            endcase

            goal = 40;
            if (ph == PRESSURE_PHASE) begin
                // receiver holds off while samples keep coming, one result per two
                write_cfg(CFG_FRAME_LENGTH, 17'd1);
                gap_max   = 0;
                burst_max = 64;
                goal      = 80;
                hold_req  = 1'b1;
            end

            start_cnt = queued_cnt;
            span      = frame_span();

            // close any pair the previous phase left open
            if (in_second || cur_index != 0) begin
                left = (cur_index + 1 >= span) ? 1 : span - cur_index;
                if (!in_second) left += span;
                repeat (left) offer(SAMPLE_W'($urandom_range(0, 255)));
            end

            while (queued_cnt - start_cnt < goal) begin
                pick = $urandom_range(0, 9);
                if (pick == 0)      style = PAIR_SAME;
                else if (pick < 3)  style = PAIR_RANDOM;
                else                style = PAIR_BLINK;
                send_pair(span, style, -1);
            end

            // sometimes stop inside a pair, so the next settings land mid frame
            if (ph != RANDOM_PHASES - 1 && $urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 2 * span - 1 > 0 ? 2 * span - 1 : 1))
                    offer(SAMPLE_W'($urandom_range(0, 255)));
            wait_idle();
        end

        if (fail_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/bll_pkg.sv
hdl/bll_front.sv
hdl/bll_queue.sv
hdl/bll_back.sv
hdl/blinking_light_locator.sv
bench/tb_top.sv
